// File: rtl/assert_macros.svh
// Assertion macros used by row_range_reduction.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rrr_pkg.sv
// Shared types and constants for the row range reduction block.
// No dependencies; used by rrr_row_alu and row_range_reduction.
package rrr_pkg;

	localparam int DEFAULT_ROWS        = 1024;
	localparam int DEFAULT_VALUE_WIDTH = 32;

	localparam int ROW_W   = 10;
	localparam int OUT_W   = 32;
	localparam int COUNT_W = 12;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_REMOVE_MISSING  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARSE_MODE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_ROW_LENGTH = 2'd2;

	// opcodes
	localparam logic OP_ACCUM = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic               remove_missing;
		logic               sparse_mode;
		logic [COUNT_W-1:0] full_row_length;
	} cfg_t;

	// per-row flags stored beside min/max
	typedef struct packed {
		logic               missing;
		logic               seen;
		logic [COUNT_W-1:0] count;
	} row_flags_t;

	typedef struct packed {
		logic empty;
		logic missing;
	} res_flags_t;

endpackage

// File: rtl/rrr_row_alu.sv
// Read-modify-write logic for one row entry: accumulate update or read and clear.
// Depends on rrr_pkg.
module rrr_row_alu #(
	parameter int VALUE_WIDTH = rrr_pkg::DEFAULT_VALUE_WIDTH
) (
	input  rrr_pkg::cfg_t                   cfg,
	input  logic                            op,
	input  logic                            row_ok,
	input  logic signed [VALUE_WIDTH-1:0]   value,
	input  logic                            entry_missing,
	input  logic signed [VALUE_WIDTH-1:0]   old_min,
	input  logic signed [VALUE_WIDTH-1:0]   old_max,
	input  rrr_pkg::row_flags_t             old_flags,
	output logic signed [VALUE_WIDTH-1:0]   new_min,
	output logic signed [VALUE_WIDTH-1:0]   new_max,
	output rrr_pkg::row_flags_t             new_flags,
	output logic signed [rrr_pkg::OUT_W-1:0] res_min,
	output logic signed [rrr_pkg::OUT_W-1:0] res_max,
	output rrr_pkg::res_flags_t             res_flags
);
	import rrr_pkg::*;

	localparam logic signed [VALUE_WIDTH-1:0] MOST_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic signed [VALUE_WIDTH-1:0] MOST_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam logic signed [VALUE_WIDTH-1:0] ZERO     = '0;

	logic signed [VALUE_WIDTH-1:0] mn;
	logic signed [VALUE_WIDTH-1:0] mx;
	logic                          rmiss;
	logic                          rseen;
	logic [COUNT_W-1:0]            cnt;

	always_comb begin
		new_min   = old_min;
		new_max   = old_max;
		new_flags = old_flags;
		mn        = MOST_POS;
		mx        = MOST_NEG;
		rmiss     = 1'b0;
		rseen     = 1'b0;
		cnt       = '0;
		if (op == OP_ACCUM) begin
			if (cfg.sparse_mode && old_flags.count != COUNT_MAX) begin
				new_flags.count = old_flags.count + 1'b1;
			end
			if (entry_missing) begin
				if (!cfg.remove_missing) begin
					new_flags.missing = 1'b1;
				end
			end else if (!old_flags.missing) begin
				if (value < old_min) begin
					new_min = value;
				end
				if (value > old_max) begin
					new_max = value;
				end
				new_flags.seen = 1'b1;
			end
		end else begin
			// read clears the row
			new_min   = MOST_POS;
			new_max   = MOST_NEG;
			new_flags = '0;
			if (row_ok) begin
				mn    = old_min;
				mx    = old_max;
				rmiss = old_flags.missing;
				rseen = old_flags.seen;
				cnt   = old_flags.count;
			end
			if (rmiss) begin
				mn = ZERO;
				mx = ZERO;
			end else if (cfg.sparse_mode && cnt < cfg.full_row_length) begin
				// unlisted entries count as zeros
				if (mn > ZERO) begin
					mn = ZERO;
				end
				if (mx < ZERO) begin
					mx = ZERO;
				end
			end
		end
		res_min           = OUT_W'(mn);
		res_max           = OUT_W'(mx);
		res_flags.missing = rmiss;
		res_flags.empty   = !rseen;
	end

endmodule

// File: rtl/row_range_reduction.sv
// Row range reduction top level: per-row min/max store, pipeline and stream ports.
// Depends on rrr_pkg, rrr_row_alu and assert_macros.svh.
// Sustains one transaction per cycle while s_tready is high: an item is captured into s1,
// its row is read from a single synchronous memory (one write port, one read port) into rd_q
// as it moves to s2, and the updated entry is written back as it leaves s2, when a read result
// is also registered onto m_tvalid. Back-to-back items on the same row are served by forwarding
// the write data into the read register. Outside the clearing pass, input is held off only
// while a finished read result waits on a stalled output. After reset a clearing pass writes
// every row, during which s_tready is low; configuration writes are taken at any time.
`include "assert_macros.svh"

module row_range_reduction #(
	parameter int ROWS        = rrr_pkg::DEFAULT_ROWS,
	parameter int VALUE_WIDTH = rrr_pkg::DEFAULT_VALUE_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [47:0]                    s_tdata,   // row_index[9:0], entry_value[41:10], zero fill
	input  logic [1:0]                     s_tuser,   // opcode[0], entry_missing[1]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [63:0]                    m_tdata,   // row_min[31:0], row_max[63:32]
	output logic [1:0]                     m_tuser,   // row_missing[0], row_empty[1]
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rrr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rrr_pkg::COUNT_W-1:0]    cfg_data
);
	import rrr_pkg::*;

	localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int WW = 2 * VALUE_WIDTH + $bits(row_flags_t);
	localparam logic [AW-1:0] LAST_ADDR = AW'(ROWS - 1);
	localparam logic [WW-1:0] CLEAR_WORD = {
		{$bits(row_flags_t){1'b0}},
		{1'b1, {(VALUE_WIDTH-1){1'b0}}},
		{1'b0, {(VALUE_WIDTH-1){1'b1}}}
	};

	// configuration
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.remove_missing  <= 1'b0;
			cfg_q.sparse_mode     <= 1'b0;
			cfg_q.full_row_length <= COUNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_REMOVE_MISSING:  cfg_q.remove_missing  <= cfg_data[0];
				CFG_SPARSE_MODE:     cfg_q.sparse_mode     <= cfg_data[0];
				CFG_FULL_ROW_LENGTH: cfg_q.full_row_length <= cfg_data;
				default: ;
			endcase
		end
	end

	// input decode
	logic [ROW_W-1:0]              in_row;
	logic signed [OUT_W-1:0]       in_value;
	logic                          in_row_ok;
	logic                          s_fire;

	assign in_row    = s_tdata[ROW_W-1:0];
	assign in_value  = s_tdata[ROW_W+OUT_W-1:ROW_W];
	assign in_row_ok = {22'd0, in_row} < 32'(ROWS);
	assign s_fire    = s_tvalid && s_tready;

	// pipeline control
	logic clearing_q;
	logic [AW-1:0] clr_addr_q;
	logic valid_s1, valid_s2;
	logic adv;
	logic out_valid_q;

	logic                          op_s1, miss_s1, row_ok_s1;
	logic [AW-1:0]                 addr_s1;
	logic signed [VALUE_WIDTH-1:0] value_s1;
	logic                          op_s2, miss_s2, row_ok_s2;
	logic [AW-1:0]                 addr_s2;
	logic signed [VALUE_WIDTH-1:0] value_s2;

	// a finished read result may only leave s2 when the output register can take it
	assign adv      = !(valid_s2 && op_s2 == OP_READ && out_valid_q && !m_tready);
	assign s_tready = !clearing_q && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_fire;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1     <= s_tuser[0];
			miss_s1   <= s_tuser[1];
			row_ok_s1 <= in_row_ok;
			addr_s1   <= AW'(in_row);
			value_s1  <= VALUE_WIDTH'(in_value);
			op_s2     <= op_s1;
			miss_s2   <= miss_s1;
			row_ok_s2 <= row_ok_s1;
			addr_s2   <= addr_s1;
			value_s2  <= value_s1;
		end
	end

	// row memory
	logic [WW-1:0] mem [ROWS];
	logic [WW-1:0] rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [WW-1:0] mem_wdata;
	logic [WW-1:0] upd_word;

	assign mem_we    = clearing_q || (adv && valid_s2 && row_ok_s2);
	assign mem_waddr = clearing_q ? clr_addr_q : addr_s2;
	assign mem_wdata = clearing_q ? CLEAR_WORD : upd_word;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	// forward the write of the item ahead when it hits the same row
	always_ff @(posedge clk) begin
		if (adv) begin
			if (mem_we && mem_waddr == addr_s1) begin
				rd_q <= mem_wdata;
			end else begin
				rd_q <= mem[addr_s1];
			end
		end
	end

	// update logic
	logic signed [VALUE_WIDTH-1:0] new_min, new_max;
	row_flags_t                    new_flags;
	logic signed [OUT_W-1:0]       res_min, res_max;
	res_flags_t                    res_flags;

	rrr_row_alu #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_alu (
		.cfg           (cfg_q),
		.op            (op_s2),
		.row_ok        (row_ok_s2),
		.value         (value_s2),
		.entry_missing (miss_s2),
		.old_min       (rd_q[VALUE_WIDTH-1:0]),
		.old_max       (rd_q[2*VALUE_WIDTH-1:VALUE_WIDTH]),
		.old_flags     (rd_q[WW-1:2*VALUE_WIDTH]),
		.new_min       (new_min),
		.new_max       (new_max),
		.new_flags     (new_flags),
		.res_min       (res_min),
		.res_max       (res_max),
		.res_flags     (res_flags)
	);

	assign upd_word = {new_flags, new_max, new_min};

	// output register
	logic [63:0]      out_data_q;
	res_flags_t       out_flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && valid_s2 && op_s2 == OP_READ) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2 && op_s2 == OP_READ) begin
			out_data_q  <= {res_max, res_min};
			out_flags_q <= res_flags;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = {out_flags_q.empty, out_flags_q.missing};

	// checks
	`ASSERT_IMPL(a_no_accept_in_clear, clearing_q, !s_tready, "item accepted during clear pass")
	`ASSERT_NEXT(a_fwd_same_row, adv && mem_we && !clearing_q && valid_s1 && mem_waddr == addr_s1, rd_q == $past(mem_wdata), "forwarded row data lost")
	`ASSERT_IMPL(a_no_out_overwrite, out_valid_q && !m_tready, !(adv && valid_s2 && op_s2 == OP_READ), "pending result overwritten")

endmodule
